@@ hw/rtl/cfdpnak_pkg.sv @@
// shared types, codes and constants of the cfdp nak pdu parser
package cfdpnak_pkg;

  localparam int MaxSegmentsDefault = 64;
  localparam int QueueDepthDefault  = 4;

  // parse stage
  typedef enum logic [1:0] {
    ST_CODE    = 2'd0,
    ST_SCOPE   = 2'd1,
    ST_SEGS    = 2'd2,
    ST_DISCARD = 2'd3
  } parse_stage_t;

  // final status codes
  localparam logic [2:0] S_OK     = 3'd0;
  localparam logic [2:0] S_SHORT  = 3'd1;
  localparam logic [2:0] S_CODE   = 3'd2;
  localparam logic [2:0] S_RAGGED = 3'd3;
  localparam logic [2:0] S_MANY   = 3'd4;

  // record kinds
  localparam logic [1:0] REC_SCOPE   = 2'd0;
  localparam logic [1:0] REC_SEGMENT = 2'd1;
  localparam logic [1:0] REC_STATUS  = 2'd2;

  // configuration register indexes
  localparam logic CFG_LARGE_FILE_MODE = 1'b0;
  localparam logic CFG_NAK_CODE        = 1'b1;

  localparam logic [7:0] NakCodeReset = 8'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [63:0] from_offset;
    logic [63:0] to_offset;
    logic [2:0]  status;
    logic [6:0]  segment_count;
    logic        last;
  } out_rec_t;

  // one queue entry: a pair record, a status record, or both
  typedef struct packed {
    logic        has_pair;
    logic        pair_is_seg;
    logic [63:0] from_offset;
    logic [63:0] to_offset;
    logic        has_stat;
    logic [2:0]  status;
    logic [6:0]  segment_count;
  } cmd_t;

endpackage

@@ hw/rtl/cfdpnak_front.sv @@
// front end: byte parser, offset assembly and error classification
module cfdpnak_front #(
  parameter int MAX_SEGMENTS = cfdpnak_pkg::MaxSegmentsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic                  accept,
  input  cfdpnak_pkg::in_item_t item,
  output logic                  push,
  output cfdpnak_pkg::cmd_t     cmd
);

  logic                      lfm_r;
  logic [7:0]                code_r;
  logic [3:0]                fp_r, fp_nxt;
  cfdpnak_pkg::parse_stage_t stage_r, stage_nxt;
  logic [63:0]               acc_r, acc_nxt;
  logic [63:0]               held_r, held_nxt;
  logic [6:0]                cnt_r, cnt_nxt;
  logic [2:0]                err_r, err_nxt;

  logic [63:0] acc_sh;
  logic [4:0]  pos, pos_n, fs, fs2;

  assign acc_sh = {acc_r[55:0], item.data_byte};
  assign pos    = {1'b0, fp_r} + 5'd1;
  assign fs     = lfm_r ? 5'd8 : 5'd4;
  assign fs2    = {fs[3:0], 1'b0};

  always_comb begin
    fp_nxt    = fp_r;
    stage_nxt = stage_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    pos_n     = pos;
    cmd       = '0;
    if (accept) begin
      case (stage_r)
        cfdpnak_pkg::ST_CODE: begin
          if (item.data_byte != code_r) begin
            err_nxt   = cfdpnak_pkg::S_CODE;
            stage_nxt = cfdpnak_pkg::ST_DISCARD;
          end else begin
            stage_nxt = cfdpnak_pkg::ST_SCOPE;
            fp_nxt    = 4'd0;
            acc_nxt   = '0;
          end
        end
        cfdpnak_pkg::ST_SCOPE, cfdpnak_pkg::ST_SEGS: begin
          acc_nxt = acc_sh;
          if (pos == fs) begin
            held_nxt = acc_sh;
            acc_nxt  = '0;
          end
          if (pos >= fs2) begin
            acc_nxt = '0;
            pos_n   = 5'd0;
            if (stage_r == cfdpnak_pkg::ST_SCOPE) begin
              cmd.has_pair     = 1'b1;
              cmd.pair_is_seg  = 1'b0;
              cmd.from_offset  = held_r;
              cmd.to_offset    = acc_sh;
              stage_nxt        = cfdpnak_pkg::ST_SEGS;
            end else if (cnt_r >= 7'(MAX_SEGMENTS)) begin
              err_nxt   = cfdpnak_pkg::S_MANY;
              stage_nxt = cfdpnak_pkg::ST_DISCARD;
            end else begin
              cnt_nxt          = cnt_r + 7'd1;
              cmd.has_pair     = 1'b1;
              cmd.pair_is_seg  = 1'b1;
              cmd.from_offset  = held_r;
              cmd.to_offset    = acc_sh;
            end
          end
          fp_nxt = pos_n[3:0];
        end
        default: begin
        end
      endcase
      if (item.last_byte) begin
        cmd.has_stat      = 1'b1;
        cmd.segment_count = cnt_nxt;
        if (err_nxt != cfdpnak_pkg::S_OK) begin
          cmd.status = err_nxt;
        end else if (stage_nxt != cfdpnak_pkg::ST_SEGS) begin
          cmd.status = cfdpnak_pkg::S_SHORT;
        end else if (fp_nxt != 4'd0) begin
          cmd.status = cfdpnak_pkg::S_RAGGED;
        end else begin
          cmd.status = cfdpnak_pkg::S_OK;
        end
        fp_nxt    = 4'd0;
        stage_nxt = cfdpnak_pkg::ST_CODE;
        acc_nxt   = '0;
        held_nxt  = '0;
        cnt_nxt   = '0;
        err_nxt   = cfdpnak_pkg::S_OK;
      end
    end
  end

  assign push = accept && (cmd.has_pair || cmd.has_stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfm_r   <= 1'b0;
      code_r  <= cfdpnak_pkg::NakCodeReset;
      fp_r    <= '0;
      stage_r <= cfdpnak_pkg::ST_CODE;
      acc_r   <= '0;
      held_r  <= '0;
      cnt_r   <= '0;
      err_r   <= cfdpnak_pkg::S_OK;
    end else begin
      if (cfg_we && cfg_index == cfdpnak_pkg::CFG_LARGE_FILE_MODE) begin
        lfm_r <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == cfdpnak_pkg::CFG_NAK_CODE) begin
        code_r <= cfg_wdata;
      end
      fp_r    <= fp_nxt;
      stage_r <= stage_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // discarding and a recorded error go together
  a_discard_err: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == cfdpnak_pkg::ST_DISCARD) == (err_r != cfdpnak_pkg::S_OK))
    else $error("discard stage and error code disagree");

  // a partial pair exists only while offsets are being assembled
  a_fp_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (fp_r != 4'd0) |-> (stage_r == cfdpnak_pkg::ST_SCOPE ||
                        stage_r == cfdpnak_pkg::ST_SEGS))
    else $error("pair position set outside offset stages");
`endif

endmodule

@@ hw/rtl/cfdpnak_queue.sv @@
// short fifo of parsed records between front and back
module cfdpnak_queue #(
  parameter int DEPTH = cfdpnak_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfdpnak_pkg::cmd_t push_data,
  input  logic              pop,
  output cfdpnak_pkg::cmd_t head,
  output logic              empty,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cfdpnak_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // no overflow or underflow
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");
`endif

endmodule

@@ hw/rtl/cfdpnak_back.sv @@
// back end: unpacks queued entries into output records
module cfdpnak_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfdpnak_pkg::cmd_t     head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cfdpnak_pkg::out_rec_t out_data
);

  logic                  out_valid_r, out_valid_nxt;
  cfdpnak_pkg::out_rec_t out_rec_r, out_rec_nxt;
  logic                  pair_done_r, pair_done_nxt;
  logic                  load;

  assign load = !out_valid_r || !out_stall;

  always_comb begin
    pop           = 1'b0;
    pair_done_nxt = pair_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rec_nxt   = out_rec_r;
    if (load && !empty) begin
      out_valid_nxt = 1'b1;
      if (head.has_pair && !pair_done_r) begin
        out_rec_nxt.record_kind   = head.pair_is_seg ? cfdpnak_pkg::REC_SEGMENT
                                                     : cfdpnak_pkg::REC_SCOPE;
        out_rec_nxt.from_offset   = head.from_offset;
        out_rec_nxt.to_offset     = head.to_offset;
        out_rec_nxt.status        = cfdpnak_pkg::S_OK;
        out_rec_nxt.segment_count = '0;
        out_rec_nxt.last          = 1'b0;
        if (head.has_stat) begin
          pair_done_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_rec_nxt.record_kind   = cfdpnak_pkg::REC_STATUS;
        out_rec_nxt.from_offset   = '0;
        out_rec_nxt.to_offset     = '0;
        out_rec_nxt.status        = head.status;
        out_rec_nxt.segment_count = head.segment_count;
        out_rec_nxt.last          = 1'b1;
        pop           = 1'b1;
        pair_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pair_done_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pair_done_r <= pair_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_rec_r;

`ifndef NO_ASSERTIONS
  // a half-sent entry stays at the head with both parts present
  a_pair_done_head: assert property (@(posedge clk) disable iff (!rst_n)
    pair_done_r |-> (!empty && head.has_pair && head.has_stat))
    else $error("pair sent flag without a matching head entry");
`endif

endmodule

@@ hw/rtl/cfdp_nak_pdu_parser_top.sv @@
// top level of the cfdp nak pdu data-field parser
//
// in channel: one octet of the nak pdu data field per request (data_byte),
// last_byte flags the final octet. a request is taken at a clock edge with
// in_valid high and in_stall low. out channel: one record per request,
// scope pair, segment request pair or final status (last = 1).
// the front parser takes one octet per cycle while in_stall is low and
// writes any records it yields into a short queue; the back end drains
// the queue into the output register, one record per cycle while
// out_stall is low. a record reaches out_* through the queue and then
// the output register. an octet that closes a pair and also ends the
// pdu yields two records in one queue entry, which the back end sends
// one after the other, the queue absorbing octets meanwhile.
// in_stall rises only when the queue is full, so a stalled receiver
// backs up through the queue to the input side after QUEUE_DEPTH entries.
// configuration (large_file_mode, nak_code) is to be written by the user
// through cfg_* while the block is idle, which it does not enforce. rst_n
// (synchronous, active low) empties the queue and output register, sets
// large_file_mode to 0 and nak_code to 8; the parser awaits the directive code.
module cfdp_nak_pdu_parser_top #(
  parameter int MAX_SEGMENTS = cfdpnak_pkg::MaxSegmentsDefault,
  parameter int QUEUE_DEPTH  = cfdpnak_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cfdpnak_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cfdpnak_pkg::out_rec_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata
);

  // front to queue
  logic              accept;
  logic              push;
  cfdpnak_pkg::cmd_t push_cmd;

  // queue to back
  cfdpnak_pkg::cmd_t head;
  logic              q_empty, q_full, pop;

  // the front takes an octet whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  cfdpnak_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .push      (push),
    .cmd       (push_cmd)
  );

  cfdpnak_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back end: output register, splits pair plus status entries
  cfdpnak_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/cfdp_nak_pdu_parser_top_tb.sv @@
// self-checking testbench of the cfdp nak pdu parser top level
module cfdp_nak_pdu_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // a silent stretch this long means the block has hung
  localparam int unsigned IdleLimit  = 400;
  // random octets sent in each configuration phase
  localparam int unsigned PhaseBytes = 8;
  localparam int unsigned PhaseCount = 8;

  // scoreboard: a copy of the parser state that predicts every record, and
  // the store of records still to come from the block, oldest first
  class nak_scoreboard;
    cfdpnak_pkg::out_rec_t     pending_records[$];
    int unsigned               errors;
    bit                        large_mode;
    logic [7:0]                code;
    cfdpnak_pkg::parse_stage_t stage;
    logic [3:0]                pos;
    logic [63:0]               acc;
    logic [63:0]               held;
    logic [6:0]                seg_cnt;
    logic [2:0]                err;

    function new();
      errors     = 0;
      large_mode = 1'b0;
      code       = cfdpnak_pkg::NakCodeReset;
      clear_pdu();
    endfunction

    function void clear_pdu();
      stage   = cfdpnak_pkg::ST_CODE;
      pos     = '0;
      acc     = '0;
      held    = '0;
      seg_cnt = '0;
      err     = cfdpnak_pkg::S_OK;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == cfdpnak_pkg::CFG_LARGE_FILE_MODE) begin
        large_mode = val[0];
      end else begin
        code = val;
      end
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    function void queue_record(logic [1:0] kind, logic [63:0] s, logic [63:0] e,
                               logic [2:0] st, logic [6:0] cnt, logic lst);
      cfdpnak_pkg::out_rec_t r;
      r.record_kind   = kind;
      r.from_offset   = s;
      r.to_offset     = e;
      r.status        = st;
      r.segment_count = cnt;
      r.last          = lst;
      pending_records.push_back(r);
    endfunction

    // one accepted octet: advance the parse and queue what it yields
    function void decode_octet(cfdpnak_pkg::in_item_t it);
      int unsigned fs;
      int unsigned p;
      logic [63:0] end_val;
      logic [2:0]  st;
      fs = large_mode ? 8 : 4;
      case (stage)
        cfdpnak_pkg::ST_CODE: begin
          if (it.data_byte != code) begin
            err   = cfdpnak_pkg::S_CODE;
            stage = cfdpnak_pkg::ST_DISCARD;
          end else begin
            stage = cfdpnak_pkg::ST_SCOPE;
            pos   = '0;
            acc   = '0;
          end
        end
        cfdpnak_pkg::ST_SCOPE, cfdpnak_pkg::ST_SEGS: begin
          p   = int'(pos) + 1;
          acc = {acc[55:0], it.data_byte};
          // width re-read on every octet, so a mode change shifts the split
          if (p == fs) begin
            held = acc;
            acc  = '0;
          end
          if (p >= 2 * fs) begin
            end_val = acc;
            acc     = '0;
            p       = 0;
            if (stage == cfdpnak_pkg::ST_SCOPE) begin
              queue_record(cfdpnak_pkg::REC_SCOPE, held, end_val, cfdpnak_pkg::S_OK,
                           '0, 1'b0);
              stage = cfdpnak_pkg::ST_SEGS;
            end else if (int'(seg_cnt) >= cfdpnak_pkg::MaxSegmentsDefault) begin
              err   = cfdpnak_pkg::S_MANY;
              stage = cfdpnak_pkg::ST_DISCARD;
            end else begin
              seg_cnt++;
              queue_record(cfdpnak_pkg::REC_SEGMENT, held, end_val, cfdpnak_pkg::S_OK,
                           '0, 1'b0);
            end
          end
          pos = p[3:0];
        end
        default: ;
      endcase
      if (it.last_byte) begin
        if (err != cfdpnak_pkg::S_OK)                st = err;
        else if (stage != cfdpnak_pkg::ST_SEGS)      st = cfdpnak_pkg::S_SHORT;
        else if (pos != '0)                          st = cfdpnak_pkg::S_RAGGED;
        else                                         st = cfdpnak_pkg::S_OK;
        queue_record(cfdpnak_pkg::REC_STATUS, '0, '0, st, seg_cnt, 1'b1);
        clear_pdu();
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 100) begin
        $display("bad %s: got %h want %h at %0t", what, got, want, $realtime);
      end
      errors++;
    endtask

    task check_record(cfdpnak_pkg::out_rec_t got);
      cfdpnak_pkg::out_rec_t want;
      if (pending_records.size() == 0) begin
        report_mismatch("record_kind, nothing expected", 64'(got.record_kind), '0);
        return;
      end
      want = pending_records.pop_front();
      if (got.record_kind !== want.record_kind)
        report_mismatch("record_kind", 64'(got.record_kind), 64'(want.record_kind));
      if (got.from_offset !== want.from_offset)
        report_mismatch("from_offset", got.from_offset, want.from_offset);
      if (got.to_offset !== want.to_offset)
        report_mismatch("to_offset", got.to_offset, want.to_offset);
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.segment_count !== want.segment_count)
        report_mismatch("segment_count", 64'(got.segment_count), 64'(want.segment_count));
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cfdpnak_pkg::in_item_t in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cfdpnak_pkg::out_rec_t out_data;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = cfdpnak_pkg::CFG_LARGE_FILE_MODE;
  logic [7:0]            cfg_wdata = '0;

  nak_scoreboard sb = new();

  // octets of the pdu being built, sent as one run of requests
  cfdpnak_pkg::in_item_t pdu_q[$];
  int unsigned           sent_bytes = 0;
  // stretches where a side never idles
  bit                    tx_calm = 1'b0;
  bit                    rx_calm = 1'b0;

  cfdp_nak_pdu_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // pdu building helpers
  // ---------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    cfdpnak_pkg::in_item_t it;
    it.data_byte = b;
    it.last_byte = 1'b0;
    pdu_q.push_back(it);
  endfunction

  // big-endian, as many octets as the current mode says
  function automatic void add_offset(logic [63:0] v);
    int fs;
    fs = sb.large_mode ? 8 : 4;
    for (int i = fs - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] rand_offset();
    return {$urandom, $urandom};
  endfunction

  function automatic void finish_pdu();
    pdu_q[pdu_q.size() - 1].last_byte = 1'b1;
  endfunction

  // code, scope pair and nseg segment request pairs
  function automatic void build_full(int nseg, bit fin);
    add_byte(sb.code);
    add_offset(rand_offset());
    add_offset(rand_offset());
    repeat (nseg) begin
      add_offset(rand_offset());
      add_offset(rand_offset());
    end
    if (fin) finish_pdu();
  endfunction

  function automatic void build_random_pdu();
    int shape;
    int cut;
    int fs;
    fs    = sb.large_mode ? 8 : 4;
    shape = $urandom_range(0, 9);
    case (shape)
      // truncated anywhere: too short, ragged, or ok by chance
      6: begin
        build_full($urandom_range(0, 3), 1'b0);
        cut = $urandom_range(1, pdu_q.size());
        while (pdu_q.size() > cut) void'(pdu_q.pop_back());
        finish_pdu();
      end
      // wrong directive code, the rest must be suppressed
      7: begin
        add_byte(sb.code ^ 8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
        finish_pdu();
      end
      // noise, with last flags scattered through it
      8: begin
        repeat ($urandom_range(1, 12)) begin
          add_byte(8'($urandom));
          pdu_q[pdu_q.size() - 1].last_byte = ($urandom_range(0, 3) == 0);
        end
        finish_pdu();
      end
      // ends part way through a segment request pair
      9: begin
        build_full($urandom_range(0, 2), 1'b0);
        repeat ($urandom_range(1, 2 * fs - 1)) add_byte(8'($urandom));
        finish_pdu();
      end
      default: build_full($urandom_range(0, 4), 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------

  // one octet request, after a random idle gap; valid stays high when the
  // gap is zero so back-to-back requests keep the channel full
  task automatic send_item(cfdpnak_pkg::in_item_t item);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.decode_octet(item);
    sent_bytes++;
  endtask

  task automatic send_pdu();
    tx_calm = ($urandom_range(0, 3) == 0);
    foreach (pdu_q[i]) send_item(pdu_q[i]);
    pdu_q.delete();
  endtask

  // drop valid, let every predicted record arrive, then a few spare cycles
  // since an octet inside a pair yields nothing to wait on
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // enable high for one edge, then dropped before the task returns so writes never overlap
  task automatic write_cfg(logic idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall before each record, checked when taken
  // ---------------------------------------------------------------------
  initial begin : receiver
    int hold;
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_record(out_data);
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: too long without any request taken on either side
  // ---------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("cfdp_nak_pdu_parser_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    bit          mode;
    logic [7:0]  nak;
    int unsigned phase_start;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pdu of the code octet alone, too short
    add_byte(sb.code);
    finish_pdu();
    send_pdu();

    // directed: wrong code, the following octet is suppressed
    add_byte(sb.code ^ 8'h5a);
    add_byte(8'hff);
    finish_pdu();
    send_pdu();

    // directed: offset extremes in small-file mode, then a ragged tail
    add_byte(sb.code);
    add_offset('0);
    add_offset(64'h0000_0000_ffff_ffff);
    add_offset(64'h0000_0000_ffff_ffff);
    add_offset('0);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h80);
    finish_pdu();
    send_pdu();

    // directed: mode changed inside a pdu, three octets of scope in large
    // mode, then small mode so the start closes on the next octet
    settle_block();
    write_cfg(cfdpnak_pkg::CFG_LARGE_FILE_MODE, 8'd1);
    add_byte(sb.code);
    add_byte(8'h12);
    add_byte(8'h34);
    add_byte(8'h56);
    send_pdu();
    settle_block();
    write_cfg(cfdpnak_pkg::CFG_LARGE_FILE_MODE, 8'd0);
    add_byte(8'h78);
    add_byte(8'h9a);
    add_byte(8'hbc);
    add_byte(8'hde);
    add_byte(8'hf0);
    finish_pdu();
    send_pdu();

    // random phases, each under its own configuration
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle_block();
      if (ph < 2)       mode = ph[0];
      else if (ph == 4) mode = 1'b0;
      else              mode = $urandom_range(0, 1);
      case (ph)
        2:       nak = 8'h00;
        3:       nak = 8'hff;
        5, 7:    nak = 8'($urandom);
        default: nak = cfdpnak_pkg::NakCodeReset;
      endcase
      write_cfg(cfdpnak_pkg::CFG_LARGE_FILE_MODE, 8'(mode));
      write_cfg(cfdpnak_pkg::CFG_NAK_CODE, nak);

      // small-file mode: every legal request, then one request too many
      if (ph == 4) begin
        build_full(cfdpnak_pkg::MaxSegmentsDefault + 1, 1'b1);
        send_pdu();
      end

      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PhaseBytes) begin
        build_random_pdu();
        send_pdu();
      end
    end

    // drain and let any late record show up
    settle_block();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("cfdp_nak_pdu_parser_top: match");
    end else begin
      $display("cfdp_nak_pdu_parser_top: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cfdpnak_pkg.sv
hw/rtl/cfdpnak_front.sv
hw/rtl/cfdpnak_queue.sv
hw/rtl/cfdpnak_back.sv
hw/rtl/cfdp_nak_pdu_parser_top.sv
tb/cfdp_nak_pdu_parser_top_tb.sv
